// File: sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: sv/sspd_pkg.sv
`default_nettype none

package sspd_pkg;

	localparam int SAMPLES_PER_PACKET = 512;
	localparam int POS_W = $clog2(SAMPLES_PER_PACKET + 1);
	localparam int SEQ_W = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;

	// header bits
	localparam int HDR_TRIG_BIT = 6;
	localparam int HDR_SAMPLE_BIT = 5;
	localparam int HDR_WAVE_BIT = 4;

	localparam logic [SEQ_W-1:0] FRAME_MAX_PACKETS = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_MODE      = 3'd0,
		REG_CH1_GROUND        = 3'd1,
		REG_CH2_GROUND        = 3'd2,
		REG_CH1_POSITION      = 3'd3,
		REG_CH2_POSITION      = 3'd4,
		REG_PACKETS_PER_FRAME = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_CH1  = 2'd1,
		MODE_CH2  = 2'd2,
		MODE_BOTH = 2'd3
	} chan_mode_t;

	typedef enum logic [1:0] {
		CH_ONE  = 2'd0,
		CH_TWO  = 2'd1,
		CH_NONE = 2'd2
	} chan_code_t;

	typedef struct packed {
		chan_mode_t        channel_mode;
		logic              ch1_ground;
		logic              ch2_ground;
		logic [7:0]        ch1_position;
		logic [7:0]        ch2_position;
		logic [SEQ_W-1:0]  packets_per_frame;
	} cfg_t;

endpackage

`default_nettype wire

// File: sv/sspd_regs.sv
`default_nettype none

module sspd_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sspd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sspd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output sspd_pkg::cfg_t                           cfg
);

	sspd_pkg::cfg_t cfg_q;

	// writes are registered and never stall
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_mode      <= sspd_pkg::MODE_BOTH;
			cfg_q.ch1_ground        <= 1'b0;
			cfg_q.ch2_ground        <= 1'b0;
			cfg_q.ch1_position      <= 8'd128;
			cfg_q.ch2_position      <= 8'd128;
			cfg_q.packets_per_frame <= sspd_pkg::FRAME_MAX_PACKETS;
		end else if (cfg_valid && cfg_ready) begin
			case (sspd_pkg::reg_idx_t'(cfg_index))
				sspd_pkg::REG_CHANNEL_MODE: begin
					cfg_q.channel_mode <= sspd_pkg::chan_mode_t'(cfg_data[1:0]);
				end
				sspd_pkg::REG_CH1_GROUND: begin
					cfg_q.ch1_ground <= cfg_data[0];
				end
				sspd_pkg::REG_CH2_GROUND: begin
					cfg_q.ch2_ground <= cfg_data[0];
				end
				sspd_pkg::REG_CH1_POSITION: begin
					cfg_q.ch1_position <= cfg_data[7:0];
				end
				sspd_pkg::REG_CH2_POSITION: begin
					cfg_q.ch2_position <= cfg_data[7:0];
				end
				sspd_pkg::REG_PACKETS_PER_FRAME: begin
					cfg_q.packets_per_frame <= cfg_data[sspd_pkg::SEQ_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/scope_sample_packet_deframer.sv
// Sample packet deframer for an oscilloscope byte stream.
// Input channel (in_valid/in_ready) carries one byte per beat with
// start_of_packet marking the header byte. Output channel (out_valid/out_ready)
// carries one sample beat per accepted payload byte: channel code, sample value,
// and frame_end with the header flags on the last byte of the last packet.
// Configuration writes go through cfg_valid/cfg_ready with a register index and
// data; cfg_ready is always high and a write takes effect the next cycle. Write
// only while the block is idle.
// An accepted byte is held in the input register, then its sample in the result
// register. Throughput is one byte per cycle unless the receiver stalls, set by
// the input register feeding the result register through one pass of counter
// and mux logic. Header bytes and ignored bytes produce no output beat.
// When the receiver stalls, the finished sample waits in the output register and
// one more byte is held in the input register; in_ready then drops.
// Reset clears the sequence count, packet state and both registers' valid flags,
// and loads the register defaults: both channels, no grounding, position 128,
// sixteen packets per frame.
`default_nettype none

`include "assert_macros.svh"

module scope_sample_packet_deframer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          data_byte,
	input  wire logic                                start_of_packet,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               channel,
	output logic [7:0]                               sample,
	output logic                                     frame_end,
	output logic                                     trigger_matched,
	output logic                                     wave_found,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [sspd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sspd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int POS_W = sspd_pkg::POS_W;
	localparam int SEQ_W = sspd_pkg::SEQ_W;

	sspd_pkg::cfg_t cfg;

	sspd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sop_s1;

	// packet state
	logic [SEQ_W-1:0] exp_seq_q;
	logic [POS_W-1:0] pos_q;
	logic             accepted_q;
	logic             final_q;
	logic             trig_flag_q;
	logic             wave_flag_q;

	// result register
	logic       out_valid_q;
	logic [1:0] channel_q;
	logic [7:0] sample_q;
	logic       frame_end_q;
	logic       trig_q;
	logic       wave_q;

	logic             out_free;
	logic             advance;
	logic [SEQ_W-1:0] hdr_seq;
	logic [SEQ_W-1:0] hdr_seq_next;
	logic             emit;
	logic [1:0]       ch_sel;
	logic [7:0]       smp_sel;
	logic             last_byte;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	assign hdr_seq      = {1'b0, byte_s1[3:0]};
	assign hdr_seq_next = hdr_seq + SEQ_W'(1);

	assign emit = !sop_s1 && accepted_q && (pos_q < POS_W'(sspd_pkg::SAMPLES_PER_PACKET));
	assign last_byte = final_q && (pos_q == POS_W'(sspd_pkg::SAMPLES_PER_PACKET - 1));

	always_comb begin
		case (cfg.channel_mode)
			sspd_pkg::MODE_NONE: ch_sel = sspd_pkg::CH_NONE;
			sspd_pkg::MODE_CH1:  ch_sel = sspd_pkg::CH_ONE;
			sspd_pkg::MODE_CH2:  ch_sel = sspd_pkg::CH_TWO;
			// both: even payload bytes channel one, odd channel two
			default: ch_sel = pos_q[0] ? sspd_pkg::CH_TWO : sspd_pkg::CH_ONE;
		endcase
		case (ch_sel)
			sspd_pkg::CH_ONE: smp_sel = cfg.ch1_ground ? cfg.ch1_position : byte_s1;
			sspd_pkg::CH_TWO: smp_sel = cfg.ch2_ground ? cfg.ch2_position : byte_s1;
			default:          smp_sel = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			sop_s1  <= start_of_packet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_seq_q   <= '0;
			pos_q       <= '0;
			accepted_q  <= 1'b0;
			final_q     <= 1'b0;
			trig_flag_q <= 1'b0;
			wave_flag_q <= 1'b0;
		end else if (advance) begin
			if (sop_s1) begin
				pos_q       <= '0;
				accepted_q  <= 1'b0;
				final_q     <= 1'b0;
				trig_flag_q <= byte_s1[sspd_pkg::HDR_TRIG_BIT];
				wave_flag_q <= byte_s1[sspd_pkg::HDR_WAVE_BIT];
				if (byte_s1[sspd_pkg::HDR_SAMPLE_BIT]) begin
					if (exp_seq_q != hdr_seq) begin
						exp_seq_q <= '0;
					end else begin
						accepted_q <= 1'b1;
						if (hdr_seq_next == cfg.packets_per_frame) begin
							final_q   <= 1'b1;
							exp_seq_q <= '0;
						end else begin
							exp_seq_q <= hdr_seq_next;
						end
					end
				end
			end else if (emit) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			channel_q   <= ch_sel;
			sample_q    <= smp_sel;
			frame_end_q <= last_byte;
			trig_q      <= last_byte && trig_flag_q;
			wave_q      <= last_byte && wave_flag_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign channel         = channel_q;
	assign sample          = sample_q;
	assign frame_end       = frame_end_q;
	assign trigger_matched = trig_q;
	assign wave_found      = wave_q;

	`ASSERT_NEVER(a_pos_bound, clk, arst_n, pos_q > POS_W'(sspd_pkg::SAMPLES_PER_PACKET))
	`ASSERT_NEVER(a_seq_bound, clk, arst_n, exp_seq_q > sspd_pkg::FRAME_MAX_PACKETS)
	`ASSERT_PROP(a_final_acc, clk, arst_n, final_q |-> accepted_q)
	`ASSERT_PROP(a_flags_at_end, clk, arst_n, (out_valid_q && !frame_end_q) |-> (!trig_q && !wave_q))
	`ASSERT_PROP(a_s1_hold, clk, arst_n, (valid_s1 && !advance) |=> valid_s1)

endmodule

`default_nettype wire
